// ----- rtl/lpl_pkg.sv -----
// Package for the stereo look-ahead peak limiter.
// Sizes, fixed-point constants, payload/config/control types.
// No dependencies.
`default_nettype none
package lpl_pkg;

  localparam int SAMPLE_BITS       = 24;
  localparam int RING_DEPTH        = 1024;
  localparam int LOOKAHEAD_SAMPLES = 580;

  localparam int RING_AW     = $clog2(RING_DEPTH);
  localparam int RD_OFFSET   = (RING_DEPTH - (LOOKAHEAD_SAMPLES % RING_DEPTH)) % RING_DEPTH;
  localparam int GAIN_W      = 17;
  localparam int COEF_W      = 16;
  localparam int QUO_BITS    = 16;
  localparam int CNT_W       = $clog2(QUO_BITS);
  localparam int LEVEL_SHIFT = SAMPLE_BITS - 16;
  localparam int CFG_IDX_W   = 2;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(65536);

  // floor(0.977 * full scale)
  localparam logic [SAMPLE_BITS-1:0] OUT_LIMIT =
    SAMPLE_BITS'(((64'd1 << (SAMPLE_BITS - 1)) * 64'd977) / 64'd1000);

  localparam logic [CFG_IDX_W-1:0] REG_CEILING     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE     = 2'd3;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
  } lpl_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic [GAIN_W-1:0]             left_gain;
    logic [GAIN_W-1:0]             right_gain;
  } lpl_out_t;

  typedef struct packed {
    logic [15:0] ceiling;
    logic [15:0] output_gain;
    logic [15:0] attack_coefficient;
    logic [15:0] release_coefficient;
  } lpl_cfg_t;

  // datapath step strobes from the sequencer
  typedef struct packed {
    logic load;
    logic div;
    logic smul;
    logic sadd;
    logic gmul;
    logic pmul;
  } lpl_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/lpl_ram.sv -----
// Generic single-port-write, single-port-read RAM, registered read.
// Read data holds when no read is issued. No dependencies.
`default_nettype none
module lpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lpl_chan.sv -----
// One limiter channel: serial gain divider, gain smoothing, sample gain
// and output post-scale with clamp. Depends on lpl_pkg.
`default_nettype none
module lpl_chan (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire lpl_pkg::lpl_ctl_t                     ctl,
  input  wire lpl_pkg::lpl_cfg_t                     cfg,
  input  wire logic signed [lpl_pkg::SAMPLE_BITS-1:0] sample,
  input  wire logic signed [lpl_pkg::SAMPLE_BITS-1:0] delayed,
  output      logic signed [lpl_pkg::SAMPLE_BITS-1:0] gained,
  output      logic [lpl_pkg::GAIN_W-1:0]             gain,
  output      logic signed [lpl_pkg::SAMPLE_BITS-1:0] result
);

  localparam int SB = lpl_pkg::SAMPLE_BITS;
  localparam int GW = lpl_pkg::GAIN_W;
  localparam int CW = lpl_pkg::COEF_W;
  localparam int QB = lpl_pkg::QUO_BITS;

  logic [SB-1:0]       mag;
  logic                neg;
  logic                over;
  logic [SB:0]         rem;
  logic [QB-1:0]       quo;
  logic [GW-1:0]       want;
  logic                down;
  logic [GW+CW-1:0]    prod_s;
  logic [SB+GW-1:0]    prod_g;
  logic [SB+15:0]      prod_p;
  logic                post_neg;

  logic [SB-1:0]       level;
  logic [SB-1:0]       abs_in;
  logic [SB:0]         rem2;
  logic                ge;
  logic [GW-1:0]       want_next;
  logic                down_next;
  logic [GW-1:0]       diff;
  logic [CW-1:0]       coef;
  logic [GW-1:0]       step;
  logic [SB-1:0]       gained_mag;
  logic [SB-1:0]       abs_del;
  logic [SB+3:0]       scaled;
  logic [SB-1:0]       clamped;

  always_comb begin
    level      = SB'(cfg.ceiling) << lpl_pkg::LEVEL_SHIFT;
    abs_in     = sample[SB-1] ? SB'(-sample) : SB'(sample);
    rem2       = {rem[SB-1:0], 1'b0};
    ge         = rem2 >= {1'b0, mag};
    want_next  = over ? {1'b0, quo} : lpl_pkg::UNITY_GAIN;
    down_next  = want_next < gain;
    diff       = down_next ? (gain - want_next) : (want_next - gain);
    coef       = down_next ? cfg.attack_coefficient : cfg.release_coefficient;
    step       = prod_s[GW+CW-1:CW];
    gained_mag = prod_g[SB+15:16];
    gained     = neg ? -$signed(gained_mag) : $signed(gained_mag);
    abs_del    = delayed[SB-1] ? SB'(-delayed) : SB'(delayed);
    scaled     = prod_p[SB+15:12];
    clamped    = (scaled > (SB+4)'(lpl_pkg::OUT_LIMIT)) ? lpl_pkg::OUT_LIMIT
                                                         : scaled[SB-1:0];
    result     = post_neg ? -$signed(clamped) : $signed(clamped);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= lpl_pkg::UNITY_GAIN;
    end else if (ctl.sadd) begin
      gain <= down ? (want + step) : (want - step);
    end

    if (ctl.load) begin
      mag  <= abs_in;
      neg  <= sample[SB-1];
      over <= abs_in > level;
      rem  <= {1'b0, level};
      quo  <= '0;
    end
    // restoring division of (level << 16) by magnitude, one bit a cycle
    if (ctl.div) begin
      rem <= ge ? (rem2 - {1'b0, mag}) : rem2;
      quo <= {quo[QB-2:0], ge};
    end
    if (ctl.smul) begin
      want   <= want_next;
      down   <= down_next;
      prod_s <= {{CW{1'b0}}, diff} * {{GW{1'b0}}, coef};
    end
    if (ctl.gmul) begin
      prod_g <= {{GW{1'b0}}, mag} * {{SB{1'b0}}, gain};
    end
    if (ctl.pmul) begin
      prod_p   <= {16'b0, abs_del} * {{SB{1'b0}}, cfg.output_gain};
      post_neg <= delayed[SB-1];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lookahead_peak_limiter.sv -----
// Stereo look-ahead peak limiter, top level: sequencer, ring memory, config.
// Sequence per item: load, bit-serial gain divide, smoothing multiply and add, gain
// multiply, ring write, output; a new input is taken only once the previous item is done.
// An input is taken while a finished item still waits at the output register.
// Reset: synchronous; gains unity, registers default, ring reads zero until written.
// Depends on lpl_pkg, lpl_chan, lpl_ram.
`default_nettype none
module lookahead_peak_limiter (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output      logic                                in_ready,
  input  wire lpl_pkg::lpl_in_t                    in_data,
  output      logic                                out_valid,
  input  wire logic                                out_ready,
  output      lpl_pkg::lpl_out_t                   out_data,
  input  wire logic                                cfg_we,
  input  wire logic [lpl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [15:0]                         cfg_data
);

  localparam int SB = lpl_pkg::SAMPLE_BITS;
  localparam int AW = lpl_pkg::RING_AW;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_SMUL, S_SADD, S_GMUL, S_WRITE, S_OUT
  } state_t;

  state_t                        state;
  logic [lpl_pkg::CNT_W-1:0]     cnt;
  logic [AW-1:0]                 wp;
  logic                          wrapped;
  lpl_pkg::lpl_cfg_t             cfg;
  lpl_pkg::lpl_in_t              in_hold;
  lpl_pkg::lpl_ctl_t             ctl;

  logic                          accept;
  logic [AW:0]                   rp_sum;
  logic [AW-1:0]                 rp;
  logic                          hist_ok;
  logic [2*SB-1:0]               ram_q;
  logic signed [SB-1:0]          l_gained, r_gained;
  logic signed [SB-1:0]          l_delayed, r_delayed;
  logic signed [SB-1:0]          l_result, r_result;
  logic [lpl_pkg::GAIN_W-1:0]    l_gain, r_gain;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    rp_sum = {1'b0, wp} + (AW+1)'(lpl_pkg::RD_OFFSET);
    rp     = (rp_sum >= (AW+1)'(lpl_pkg::RING_DEPTH))
             ? AW'(rp_sum - (AW+1)'(lpl_pkg::RING_DEPTH)) : rp_sum[AW-1:0];
    hist_ok = wrapped || (rp <= wp);
    if (lpl_pkg::RD_OFFSET == 0) begin
      l_delayed = l_gained;
      r_delayed = r_gained;
    end else begin
      l_delayed = hist_ok ? $signed(ram_q[2*SB-1:SB]) : '0;
      r_delayed = hist_ok ? $signed(ram_q[SB-1:0]) : '0;
    end
    ctl      = '0;
    ctl.load = accept;
    ctl.div  = (state == S_DIV);
    ctl.smul = (state == S_SMUL);
    ctl.sadd = (state == S_SADD);
    ctl.gmul = (state == S_GMUL);
    ctl.pmul = (state == S_WRITE);
  end

  lpl_ram #(
    .WIDTH (2 * SB),
    .DEPTH (lpl_pkg::RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (state == S_WRITE),
    .waddr (wp),
    .wdata ({l_gained, r_gained}),
    .re    (accept),
    .raddr (rp),
    .rdata (ram_q)
  );

  lpl_chan u_left (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .cfg     (cfg),
    .sample  (in_hold.left_sample),
    .delayed (l_delayed),
    .gained  (l_gained),
    .gain    (l_gain),
    .result  (l_result)
  );

  lpl_chan u_right (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .cfg     (cfg),
    .sample  (in_hold.right_sample),
    .delayed (r_delayed),
    .gained  (r_gained),
    .gain    (r_gain),
    .result  (r_result)
  );

  // the channels latch the sample on load; in_hold only feeds that load
  always_comb begin
    in_hold = in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      wp        <= '0;
      wrapped   <= 1'b0;
      out_valid <= 1'b0;
      cfg.ceiling             <= 16'd18427;
      cfg.output_gain         <= 16'd7285;
      cfg.attack_coefficient  <= 16'd62932;
      cfg.release_coefficient <= 16'd65529;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          lpl_pkg::REG_CEILING:     cfg.ceiling             <= cfg_data;
          lpl_pkg::REG_OUTPUT_GAIN: cfg.output_gain         <= cfg_data;
          lpl_pkg::REG_ATTACK:      cfg.attack_coefficient  <= cfg_data;
          lpl_pkg::REG_RELEASE:     cfg.release_coefficient <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == lpl_pkg::CNT_W'(lpl_pkg::QUO_BITS - 1)) begin
            state <= S_SMUL;
          end
        end
        S_SMUL:  state <= S_SADD;
        S_SADD:  state <= S_GMUL;
        S_GMUL:  state <= S_WRITE;
        S_WRITE: begin
          if (wp == AW'(lpl_pkg::RING_DEPTH - 1)) begin
            wp      <= '0;
            wrapped <= 1'b1;
          end else begin
            wp <= wp + 1'b1;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid           <= 1'b1;
            out_data.left_out   <= l_result;
            out_data.right_out  <= r_result;
            out_data.left_gain  <= l_gain;
            out_data.right_gain <= r_gain;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- verif/tb_lookahead_peak_limiter.sv -----
// Self-checking testbench for the stereo look-ahead peak limiter: directed pairs,
// then bursty random audio under several register settings and idling patterns.
// Depends on lpl_pkg and lookahead_peak_limiter.
`timescale 1ns / 100ps
`default_nettype none
module tb_lookahead_peak_limiter;

  localparam int SB           = lpl_pkg::SAMPLE_BITS;
  localparam int GW           = lpl_pkg::GAIN_W;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 30;
  localparam int PRINT_CAP    = 30;
  localparam int N_DIRECTED   = 20;
  localparam int FULL_MAG     = 1 << (SB - 1);

  localparam lpl_pkg::lpl_cfg_t DEFAULT_CFG =
    '{16'd18427, 16'd7285, 16'd62932, 16'd65529};
  localparam lpl_pkg::lpl_out_t QUIET_FRAME =
    '{24'sd0, 24'sd0, lpl_pkg::UNITY_GAIN, lpl_pkg::UNITY_GAIN};

  localparam int IDLE_SEND [4] = '{0, 54, 0, 21};
  localparam int IDLE_RECV [4] = '{0, 0, 54, 21};

  typedef enum int {SK_RANDOM, SK_QUIET, SK_NEAR, SK_LOUD, SK_EDGE, SK_SILENT} sample_kind_t;

  typedef struct packed {
    logic signed [SB-1:0] left_in;
    logic signed [SB-1:0] right_in;
    logic                 typed;
    lpl_pkg::lpl_out_t    frame;
  } dir_row_t;

  // default ceiling level in sample units is 4717312
  localparam dir_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{24'sd0,         24'sd0,        1'b1, QUIET_FRAME},
    '{24'sd1,        -24'sd1,        1'b1, QUIET_FRAME},
    '{24'sd4717312,  -24'sd4717312,  1'b1, QUIET_FRAME},
    '{-24'sd4717312,  24'sd4717312,  1'b1, QUIET_FRAME},
    '{24'sd4717313,   24'sd0,        1'b0, '0},
    '{24'sd8388607,  -24'sd8388608,  1'b0, '0},
    '{-24'sd8388608,  24'sd8388607,  1'b0, '0},
    '{24'sd0,         24'sd0,        1'b0, '0},
    '{24'sd0,         24'sd0,        1'b0, '0},
    '{24'sd123456,   -24'sd654321,   1'b0, '0},
    '{-24'sd1,        24'sd1,        1'b0, '0},
    '{24'sd8388607,   24'sd8388607,  1'b0, '0},
    '{-24'sd8388608, -24'sd8388608,  1'b0, '0},
    '{24'sd4194304,  -24'sd4194304,  1'b0, '0},
    '{24'sd5592405,  -24'sd5592406,  1'b0, '0},
    '{-24'sd5592406,  24'sd5592405,  1'b0, '0},
    '{24'sd0,         24'sd8388607,  1'b0, '0},
    '{24'sd8388607,   24'sd0,        1'b0, '0},
    '{24'sd2,        -24'sd2,        1'b0, '0},
    '{24'sd0,         24'sd0,        1'b0, '0}
  };

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  lpl_pkg::lpl_in_t                  in_data = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  lpl_pkg::lpl_out_t                 out_data;
  logic                              cfg_we = 1'b0;
  logic [lpl_pkg::CFG_IDX_W-1:0]     cfg_index = lpl_pkg::REG_CEILING;
  logic [15:0]                       cfg_data = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int stall_left     = 0;
  int mismatches     = 0;
  int cycle_count    = 0;

  // predictor state
  lpl_pkg::lpl_cfg_t    model_cfg = DEFAULT_CFG;
  logic [GW-1:0]        gain_l = lpl_pkg::UNITY_GAIN;
  logic [GW-1:0]        gain_r = lpl_pkg::UNITY_GAIN;
  logic signed [SB-1:0] ring_l [lpl_pkg::RING_DEPTH] = '{default: '0};
  logic signed [SB-1:0] ring_r [lpl_pkg::RING_DEPTH] = '{default: '0};
  int                   wr_pos = 0;

  lpl_pkg::lpl_out_t limited_frames [$];

  lookahead_peak_limiter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items outstanding", cycle_count,
               limited_frames.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [63:0] magnitude(input logic signed [SB-1:0] x);
    longint v;
    v = x;
    if (v < 0) v = -v;
    return v;
  endfunction

  function automatic logic signed [SB-1:0] signed_of(input bit neg, input logic [63:0] m);
    longint v;
    v = longint'(m);
    if (neg) v = -v;
    return SB'(v);
  endfunction

  function automatic logic [GW-1:0] smoothed_gain(input logic [GW-1:0] g,
                                                  input logic signed [SB-1:0] x);
    logic [63:0]   mag, level, quo, diff;
    logic [GW-1:0] target;
    mag   = magnitude(x);
    level = 64'(model_cfg.ceiling) << lpl_pkg::LEVEL_SHIFT;
    if (mag <= level) begin
      target = lpl_pkg::UNITY_GAIN;
    end else begin
      quo    = (level << 16) / mag;
      target = (quo > 64'(lpl_pkg::UNITY_GAIN)) ? lpl_pkg::UNITY_GAIN : quo[GW-1:0];
    end
    if (target < g) begin
      diff = 64'(g - target);
      return target + GW'((diff * 64'(model_cfg.attack_coefficient)) >> 16);
    end
    diff = 64'(target - g);
    return target - GW'((diff * 64'(model_cfg.release_coefficient)) >> 16);
  endfunction

  function automatic logic signed [SB-1:0] gained(input logic signed [SB-1:0] x,
                                                  input logic [GW-1:0] g);
    return signed_of(x < 0, (magnitude(x) * 64'(g)) >> 16);
  endfunction

  function automatic logic signed [SB-1:0] post_scaled(input logic signed [SB-1:0] r);
    logic [63:0] m;
    m = (magnitude(r) * 64'(model_cfg.output_gain)) >> 12;
    if (m > 64'(lpl_pkg::OUT_LIMIT)) m = 64'(lpl_pkg::OUT_LIMIT);
    return signed_of(r < 0, m);
  endfunction

  // one sample pair through the limiter: gains, ring write, delayed read
  function automatic lpl_pkg::lpl_out_t limit_step(input lpl_pkg::lpl_in_t pair);
    lpl_pkg::lpl_out_t res;
    int                rd;
    gain_l = smoothed_gain(gain_l, pair.left_sample);
    gain_r = smoothed_gain(gain_r, pair.right_sample);
    ring_l[wr_pos] = gained(pair.left_sample, gain_l);
    ring_r[wr_pos] = gained(pair.right_sample, gain_r);
    rd     = (wr_pos + lpl_pkg::RD_OFFSET) % lpl_pkg::RING_DEPTH;
    wr_pos = (wr_pos + 1) % lpl_pkg::RING_DEPTH;
    res.left_out   = post_scaled(ring_l[rd]);
    res.right_out  = post_scaled(ring_r[rd]);
    res.left_gain  = gain_l;
    res.right_gain = gain_r;
    return res;
  endfunction

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic signed [63:0] got,
                             input logic signed [63:0] want);
    if (got !== want) flag_error($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin
    lpl_pkg::lpl_out_t due;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (limited_frames.size() == 0) begin
          flag_error($sformatf("result with nothing pending: %p", out_data));
        end else begin
          due = limited_frames.pop_front();
          check_field("left_out", 64'(out_data.left_out), 64'(due.left_out));
          check_field("right_out", 64'(out_data.right_out), 64'(due.right_out));
          check_field("left_gain", 64'(out_data.left_gain), 64'(due.left_gain));
          check_field("right_gain", 64'(out_data.right_gain), 64'(due.right_gain));
        end
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_pair(input lpl_pkg::lpl_in_t pair, input bit typed,
                           input lpl_pkg::lpl_out_t typed_frame);
    lpl_pkg::lpl_out_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pair;
    do @(posedge clk); while (!in_ready);
    predicted = limit_step(pair);
    limited_frames.push_back(typed ? typed_frame : predicted);
  endtask

  task automatic write_reg(input logic [lpl_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      lpl_pkg::REG_CEILING:     model_cfg.ceiling             = val;
      lpl_pkg::REG_OUTPUT_GAIN: model_cfg.output_gain         = val;
      lpl_pkg::REG_ATTACK:      model_cfg.attack_coefficient  = val;
      lpl_pkg::REG_RELEASE:     model_cfg.release_coefficient = val;
      default: ;
    endcase
  endtask

  task automatic load_config(input lpl_pkg::lpl_cfg_t c);
    write_reg(lpl_pkg::REG_CEILING, c.ceiling);
    write_reg(lpl_pkg::REG_OUTPUT_GAIN, c.output_gain);
    write_reg(lpl_pkg::REG_ATTACK, c.attack_coefficient);
    write_reg(lpl_pkg::REG_RELEASE, c.release_coefficient);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (limited_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SB-1:0] make_sample(input sample_kind_t kind);
    int lvl, m;
    lvl = int'(model_cfg.ceiling) << lpl_pkg::LEVEL_SHIFT;
    if (lvl > FULL_MAG - 1) lvl = FULL_MAG - 1;
    case (kind)
      SK_RANDOM: return SB'($urandom);
      SK_QUIET:  m = $urandom_range(0, lvl);
      SK_NEAR: begin
        m = lvl - 8 + int'($urandom_range(0, 16));
        if (m < 0) m = 0;
        if (m > FULL_MAG) m = FULL_MAG;
      end
      SK_LOUD: m = (lvl >= FULL_MAG - 1) ? $urandom_range(0, FULL_MAG)
                                        : $urandom_range(lvl + 1, FULL_MAG);
      SK_EDGE: m = ($urandom_range(0, 1) != 0) ? FULL_MAG : $urandom_range(0, 1);
      default: m = 0;
    endcase
    if ($urandom_range(0, 1) != 0) m = -m;
    return SB'(m);
  endfunction

  // bursts of one signal character: quiet passages, peaks, transients, silence
  task automatic run_random(input int count);
    int               done, burst;
    sample_kind_t     kind_l, kind_r;
    lpl_pkg::lpl_in_t pair;
    done = 0;
    while (done < count) begin
      kind_l = sample_kind_t'($urandom_range(SK_RANDOM, SK_SILENT));
      kind_r = ($urandom_range(0, 3) == 0) ? sample_kind_t'($urandom_range(SK_RANDOM, SK_SILENT))
                                          : kind_l;
      burst = $urandom_range(1, 48);
      for (int k = 0; k < burst && done < count; k++) begin
        pair.left_sample  = make_sample(kind_l);
        pair.right_sample = make_sample(kind_r);
        send_pair(pair, 1'b0, '0);
        done++;
      end
    end
  endtask

  task automatic run_phase(input lpl_pkg::lpl_cfg_t c, input int count, input int send_pct,
                           input int recv_pct, input int hold);
    load_config(c);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    stall_left     = hold;
    run_random(count);
    in_valid <= 1'b0;
    drain();
  endtask

  initial begin
    lpl_pkg::lpl_cfg_t c;
    int                pick;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_pair('{DIRECTED_ROWS[i].left_in, DIRECTED_ROWS[i].right_in},
                DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].frame);
    end
    in_valid <= 1'b0;
    drain();

    run_phase(DEFAULT_CFG, 300, 0, 0, 0);
    run_phase('{16'd0, 16'd65535, 16'd0, 16'd0}, 150, 54, 0, 0);
    run_phase('{16'd65535, 16'd4096, 16'd65535, 16'd65535}, 200, 0, 54, 0);
    run_phase('{16'd3277, 16'd40017, 16'd62932, 16'd65529}, 250, 21, 21, 0);
    // long output hold while items keep coming: input side must back up
    run_phase('{16'd32768, 16'd4002, 16'd30000, 16'd1000}, 250, 0, 0, 400);
    for (int p = 0; p < 4; p++) begin
      c    = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
      pick = $urandom_range(0, 3);
      run_phase(c, 120, IDLE_SEND[pick], IDLE_RECV[pick], 0);
    end

    if (mismatches == 0 && limited_frames.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
